FILE: rtl/toroidal_voxel_grid_addresser_core_macros.svh
// assertion macros for the voxel grid addresser
// used by the controller and the top level
`ifndef TOROIDAL_VOXEL_GRID_ADDRESSER_CORE_MACROS_SVH
`define TOROIDAL_VOXEL_GRID_ADDRESSER_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define TVGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define TVGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/tvga_pkg.sv
// package for the voxel grid addresser: widths, commands and status types
// no dependencies
`default_nettype none
package tvga_pkg;
    localparam int IndexBits = 20;
    localparam int HalfBits  = 8;
    localparam int SizeBits  = HalfBits + 1;
    localparam int AddrBits  = 27;
    localparam int SliceBits = 9;
    // wide enough for a shift of two indexes
    localparam int DiffBits  = IndexBits + 1;
    localparam int CntBits   = 5;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_MOVE   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_HALF_X = 2'd0;
    localparam logic [1:0] REG_HALF_Y = 2'd1;
    localparam logic [1:0] REG_HALF_Z = 2'd2;

    typedef struct packed {
        logic load;      // capture input beat, start axis x
        logic div_start; // start floor modulo on current axis
        logic div_step;  // one divider bit
        logic axis_done; // fold current axis result
        logic next_axis; // advance axis
        logic finish;    // form result and, on a move, update origin
    } t_cmd;

    typedef struct packed {
        logic last_bit;
        logic last_axis;
    } t_stat;
endpackage
`default_nettype wire

FILE: rtl/tvga_stream_if.sv
// valid/ready stream interface carrying a generic payload
// no dependencies
`default_nettype none
interface tvga_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tvga_ctrl.sv
// controller state machine for the voxel grid addresser
// depends on tvga_pkg and the macros header
`default_nettype none
`include "toroidal_voxel_grid_addresser_core_macros.svh"
module tvga_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire tvga_pkg::t_stat i_stat,
    output tvga_pkg::t_cmd     o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV = 3'd2;
    localparam logic [2:0] S_AXIS = 3'd3;
    localparam logic [2:0] S_FIN = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.last_bit) n_state = S_AXIS;
            end
            S_AXIS: begin
                o_cmd.axis_done = 1'b1;
                if (i_stat.last_axis) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.next_axis = 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                // next beat may be taken as this one leaves
                if (i_out_ready) begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    `TVGA_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_cmd.div_step, !o_in_ready && !o_out_valid)
    `TVGA_ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, o_cmd.finish, o_out_valid)
    `TVGA_ASSERT_NEXT(a_load_setup, i_clk, i_rst_n, o_cmd.load, o_cmd.div_start)
endmodule
`default_nettype wire

FILE: rtl/tvga_datapath.sv
// datapath: origin and config registers, shared restoring divider, result regs
// depends on tvga_pkg
`default_nettype none
module tvga_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [tvga_pkg::HalfBits-1:0] i_cfg_data,
    input  wire logic                          i_op,
    input  wire logic [3*tvga_pkg::IndexBits-1:0] i_index,
    input  wire tvga_pkg::t_cmd                i_cmd,
    output tvga_pkg::t_stat                    o_stat,
    output logic [tvga_pkg::AddrBits-1:0]      o_addr,
    output logic                               o_inside,
    output logic                               o_reset_all,
    output logic [3*2*tvga_pkg::SliceBits-1:0] o_clear
);
    localparam int IB = tvga_pkg::IndexBits;
    localparam int HB = tvga_pkg::HalfBits;
    localparam int SB = tvga_pkg::SizeBits;
    localparam int DB = tvga_pkg::DiffBits;
    localparam int NB = DB + 1;
    localparam int XB = tvga_pkg::SliceBits;

    logic [HB-1:0] r_half [3];
    logic signed [IB-1:0] r_origin [3];
    logic signed [IB-1:0] r_g [3];
    logic r_move;
    logic [1:0] r_axis;
    logic [tvga_pkg::CntBits-1:0] r_bit;
    // divider: magnitude, remainder
    logic [NB-1:0] r_quo;
    logic [SB:0] r_rem;
    logic r_neg;
    logic signed [DB-1:0] r_shift [3];
    logic r_full;
    logic [tvga_pkg::AddrBits-1:0] r_addr;
    logic r_inside;
    logic signed [XB-1:0] r_start [3];
    logic [XB-1:0] r_count [3];

    logic [HB-1:0] w_h;
    logic [SB-1:0] w_m;
    logic signed [NB-1:0] w_val;
    logic [NB-1:0] w_mag;
    logic [SB:0] w_trial;
    logic [SB:0] w_sub;
    logic [SB:0] w_res;
    logic signed [SB:0] w_cen;
    logic signed [DB-1:0] w_s;
    logic [DB-1:0] w_sabs;
    logic w_full_now;
    logic [tvga_pkg::AddrBits+SB-1:0] w_prod;

    always_comb begin
        w_h = r_half[r_axis];
        w_m = {w_h, 1'b1};
        w_s = DB'(r_g[r_axis]) - DB'(r_origin[r_axis]);
        // value reduced: index on lookup, base or base+shift on move
        if (!r_move) w_val = NB'(r_g[r_axis]);
        else if (w_s[DB-1]) w_val = NB'(r_g[r_axis]) - NB'(signed'({1'b0, w_h}));
        else w_val = NB'(r_origin[r_axis]) - NB'(signed'({1'b0, w_h}));
        w_mag = w_val[NB-1] ? (NB'(0) - w_val) : w_val;
        w_trial = {r_rem[SB-1:0], r_quo[NB-1]};
        w_sub = w_trial - (SB+1)'(w_m);
        // floor residue from magnitude remainder
        if (r_neg && r_rem != '0) w_res = (SB+1)'(w_m) - r_rem;
        else w_res = r_rem;
        w_cen = (w_res > (SB+1)'(w_h)) ? signed'(w_res - (SB+1)'(w_m)) : signed'(w_res);
        w_sabs = w_s[DB-1] ? (DB'(0) - w_s) : w_s;
        w_full_now = w_sabs > DB'(w_m);
        w_prod = r_addr * w_m;
        o_stat.last_bit = (r_bit == tvga_pkg::CntBits'(NB - 1));
        o_stat.last_axis = (r_axis == 2'd2);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) r_half[a] <= HB'(16);
        end else if (i_cfg_we && i_cfg_index <= tvga_pkg::REG_HALF_Z) begin
            r_half[i_cfg_index] <= i_cfg_data;
        end
    end

    // origin state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) r_origin[a] <= '0;
        end else if (i_cmd.finish && r_move) begin
            for (int a = 0; a < 3; a++) r_origin[a] <= r_g[a];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_move <= i_op;
            for (int a = 0; a < 3; a++) r_g[a] <= i_index[a*IB +: IB];
            r_axis <= 2'd0;
            r_addr <= '0;
            r_inside <= 1'b1;
            r_full <= 1'b0;
        end
        if (i_cmd.div_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_neg <= w_val[NB-1];
            r_bit <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[NB-2:0], 1'b0};
            r_rem <= w_sub[SB] ? w_trial : w_sub;
            r_bit <= r_bit + 1'b1;
        end
        if (i_cmd.axis_done) begin
            r_shift[r_axis] <= w_s;
            if (w_full_now) r_full <= 1'b1;
            r_start[r_axis] <= XB'(w_cen);
            r_addr <= tvga_pkg::AddrBits'(w_prod + (tvga_pkg::AddrBits+SB)'(
                unsigned'(w_cen + signed'((SB+1)'(w_h)))));
            if (w_sabs > DB'(w_h)) r_inside <= 1'b0;
        end
        if (i_cmd.next_axis) r_axis <= r_axis + 1'b1;
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_addr <= r_move ? '0 : r_addr;
            o_inside <= !r_move && r_inside;
            o_reset_all <= r_move && r_full;
            for (int a = 0; a < 3; a++) begin
                if (!r_move || r_full || r_shift[a] == '0) begin
                    o_clear[a*2*XB +: 2*XB] <= '0;
                end else begin
                    o_clear[a*2*XB +: XB] <= r_start[a];
                    o_clear[a*2*XB+XB +: XB] <= r_shift[a][DB-1] ?
                        XB'(DB'(0) - r_shift[a]) : XB'(r_shift[a]);
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/toroidal_voxel_grid_addresser_core.sv
// top level of the voxel grid addresser
// depends on tvga_pkg, tvga_stream_if, tvga_ctrl, tvga_datapath
`default_nettype none
`include "toroidal_voxel_grid_addresser_core_macros.svh"
// Rolling 3D voxel grid addresser. For each beat (lookup or move), one
// shared restoring divider reduces each axis value modulo 2h+1 one bit
// per cycle, axes in turn. The next beat is accepted in the cycle its
// predecessor's result is taken. Input data packs {op, z, y, x};
// output data packs {clear z count,start, y, x, reset_all,
// inside_window, cell_address}.
module toroidal_voxel_grid_addresser_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    tvga_stream_if.sink     s_in,
    tvga_stream_if.source   m_out
);
    localparam int IB = tvga_pkg::IndexBits;
    tvga_pkg::t_cmd w_cmd;
    tvga_pkg::t_stat w_stat;
    logic [tvga_pkg::AddrBits-1:0] w_addr;
    logic w_inside, w_reset_all;
    logic [3*2*tvga_pkg::SliceBits-1:0] w_clear;

    tvga_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .o_out_valid(m_out.valid), .i_out_ready(m_out.ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    tvga_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_op(s_in.data[3*IB]), .i_index(s_in.data[3*IB-1:0]),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .o_addr(w_addr), .o_inside(w_inside), .o_reset_all(w_reset_all),
        .o_clear(w_clear)
    );

    // result beat payload
    assign m_out.data = {w_clear, w_reset_all, w_inside, w_addr};

    `TVGA_ASSERT_IMP(a_move_noaddr, i_clk, i_rst_n, m_out.valid && w_reset_all, w_addr == '0)
    `TVGA_ASSERT_IMP(a_lookup_noclr, i_clk, i_rst_n, m_out.valid && w_inside, !w_reset_all)
    `TVGA_ASSERT_IMP(a_full_noclr, i_clk, i_rst_n, m_out.valid && w_reset_all, w_clear == '0)
endmodule
`default_nettype wire

FILE: tb/toroidal_voxel_grid_addresser_core_test.sv
// testbench for the toroidal voxel grid addresser: directed rows, then random lookups and
// moves under several half sizes, scored against a behavioral predictor
// depends on tvga_pkg, tvga_stream_if and toroidal_voxel_grid_addresser_core
`default_nettype none
module toroidal_voxel_grid_addresser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IB = tvga_pkg::IndexBits;
    localparam int SB = tvga_pkg::SliceBits;
    localparam int AB = tvga_pkg::AddrBits;

    typedef struct packed {
        logic          op;
        logic [IB-1:0] z;
        logic [IB-1:0] y;
        logic [IB-1:0] x;
    } t_voxel_req;

    typedef struct packed {
        logic [SB-1:0] cnt_z;
        logic [SB-1:0] start_z;
        logic [SB-1:0] cnt_y;
        logic [SB-1:0] start_y;
        logic [SB-1:0] cnt_x;
        logic [SB-1:0] start_x;
        logic          reset_all;
        logic          in_window;
        logic [AB-1:0] addr;
    } t_voxel_res;

    typedef struct {
        t_voxel_req req;
        bit         typed;
        t_voxel_res res;
    } t_dir_row;

    localparam int DRAIN_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = tvga_pkg::REG_HALF_X;
    logic [7:0] i_cfg_data = '0;

    tvga_stream_if #(.W($bits(t_voxel_req))) in_if ();
    tvga_stream_if #(.W($bits(t_voxel_res))) out_if ();

    toroidal_voxel_grid_addresser_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_in        (in_if),
        .m_out       (out_if)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    longint     half_sz[3];
    longint     origin[3];
    t_voxel_res pending_res[$];
    t_dir_row   dir_rows[$];
    int         errors = 0;
    int         beats_in = 0;
    int         beats_out = 0;
    int         n_moves = 0;
    int         n_full = 0;
    bit         src_done = 0;

    function automatic longint ring_slot(longint g, longint h);
        longint m, r;
        m = 2 * h + 1;
        r = g % m;
        if (r < 0) r += m;
        if (r > h) r -= m;
        return r;
    endfunction

    // expected result of one beat, updates origin on a move
    function automatic t_voxel_res grid_result(t_voxel_req req);
        t_voxel_res r;
        longint g[3], s[3], h, m, d, st, cnt;
        longint acc;
        bit in_win, full;
        r = '0;
        g[0] = longint'($signed(req.x));
        g[1] = longint'($signed(req.y));
        g[2] = longint'($signed(req.z));
        if (req.op == tvga_pkg::OP_LOOKUP) begin
            acc = 0;
            in_win = 1;
            for (int a = 0; a < 3; a++) begin
                h = half_sz[a];
                d = g[a] - origin[a];
                if (d < 0) d = -d;
                if (d > h) in_win = 0;
                acc = acc * (2 * h + 1) + ring_slot(g[a], h) + h;
            end
            r.addr = acc[AB-1:0];
            r.in_window = in_win;
            return r;
        end
        full = 0;
        for (int a = 0; a < 3; a++) begin
            m = 2 * half_sz[a] + 1;
            s[a] = g[a] - origin[a];
            if ((s[a] < 0 ? -s[a] : s[a]) > m) full = 1;
        end
        if (full) begin
            r.reset_all = 1'b1;
        end else begin
            for (int a = 0; a < 3; a++) begin
                h = half_sz[a];
                st = 0;
                cnt = 0;
                if (s[a] > 0) begin
                    st = ring_slot(origin[a] - h, h);
                    cnt = s[a];
                end else if (s[a] < 0) begin
                    st = ring_slot(origin[a] - h + s[a], h);
                    cnt = -s[a];
                end
                case (a)
                    0: begin r.start_x = st[8:0]; r.cnt_x = cnt[8:0]; end
                    1: begin r.start_y = st[8:0]; r.cnt_y = cnt[8:0]; end
                    default: begin r.start_z = st[8:0]; r.cnt_z = cnt[8:0]; end
                endcase
            end
        end
        for (int a = 0; a < 3; a++) origin[a] = g[a];
        return r;
    endfunction

    // append an expected result to the scoreboard queue
    function automatic void queue_expected(t_voxel_res res);
        pending_res.insert(pending_res.size(), res);
    endfunction

    // append one directed stimulus row
    function automatic void add_row(logic op, logic [IB-1:0] z, logic [IB-1:0] y,
                                    logic [IB-1:0] x, bit typed, t_voxel_res res);
        t_dir_row row;
        row.req = '{op, z, y, x};
        row.typed = typed;
        row.res = res;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, beats_out);
        errors++;
    endtask

    // result beat checker
    always @(posedge i_clk) begin
        t_voxel_res got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_res.size() == 0) begin
                $display("unexpected result beat %0d", beats_out);
                errors++;
            end else begin
                want = pending_res.pop_front();
                if (got.addr != want.addr) report("cell_address", got.addr, want.addr);
                if (got.in_window != want.in_window)
                    report("inside_window", got.in_window, want.in_window);
                if (got.reset_all != want.reset_all)
                    report("reset_all", got.reset_all, want.reset_all);
                if (got.start_x != want.start_x) report("clear_start_x", got.start_x, want.start_x);
                if (got.cnt_x != want.cnt_x) report("clear_count_x", got.cnt_x, want.cnt_x);
                if (got.start_y != want.start_y) report("clear_start_y", got.start_y, want.start_y);
                if (got.cnt_y != want.cnt_y) report("clear_count_y", got.cnt_y, want.cnt_y);
                if (got.start_z != want.start_z) report("clear_start_z", got.start_z, want.start_z);
                if (got.cnt_z != want.cnt_z) report("clear_count_z", got.cnt_z, want.cnt_z);
            end
            beats_out++;
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the input
    initial begin
        int r;
        bit held = 0;
        out_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held && beats_in > 300) begin
                held = 1;
                out_if.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) out_if.ready <= 1'b1;
                else if (r < 95) out_if.ready <= 1'b0;
                else begin
                    out_if.ready <= 1'b0;
                    repeat ($urandom_range(20, 120)) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_beat(t_voxel_req req, bit typed, t_voxel_res typed_res);
        bit rdy;
        t_voxel_res pred;
        int r;
        in_if.valid <= 1'b1;
        in_if.data <= req;
        do begin
            @(negedge i_clk);
            rdy = in_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        pred = grid_result(req);
        queue_expected(typed ? typed_res : pred);
        beats_in++;
        if (req.op == tvga_pkg::OP_MOVE) n_moves++;
        if (pred.reset_all) n_full++;
        // sender gaps, mostly short, a few long
        r = $urandom_range(0, 99);
        if (r >= 50) begin
            in_if.valid <= 1'b0;
            repeat (r < 90 ? $urandom_range(1, 4) : $urandom_range(30, 150)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tvga_pkg::REG_HALF_X: half_sz[0] = longint'(val);
            tvga_pkg::REG_HALF_Y: half_sz[1] = longint'(val);
            default:              half_sz[2] = longint'(val);
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [IB-1:0] near(longint base, longint span);
        longint v;
        v = base + longint'($urandom_range(0, int'(2 * span))) - span;
        return v[IB-1:0];
    endfunction

    task automatic random_beats(int count);
        t_voxel_req req;
        longint m[3];
        int r, sel;
        for (int n = 0; n < count; n++) begin
            for (int a = 0; a < 3; a++) m[a] = 2 * half_sz[a] + 1;
            req.op = ($urandom_range(0, 99) < 25) ? tvga_pkg::OP_MOVE : tvga_pkg::OP_LOOKUP;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                req.x = IB'($urandom); req.y = IB'($urandom); req.z = IB'($urandom);
            end else if (req.op == tvga_pkg::OP_MOVE && r < 25) begin
                // shift of exactly one grid size on a random axis, or off by one on x or y
                sel = $urandom_range(0, 2);
                req.x = near(origin[0], half_sz[0]);
                req.y = near(origin[1], half_sz[1]);
                req.z = near(origin[2], half_sz[2]);
                case (sel)
                    0: req.x = IB'(origin[0] + (($urandom & 1) ? m[0] : -m[0]) + (r & 1));
                    1: req.y = IB'(origin[1] + (($urandom & 1) ? m[1] : -m[1]) - (r & 1));
                    default: req.z = IB'(origin[2] + (($urandom & 1) ? m[2] : -m[2]));
                endcase
            end else begin
                req.x = near(origin[0], req.op == tvga_pkg::OP_MOVE ? m[0] : half_sz[0] + 2);
                req.y = near(origin[1], req.op == tvga_pkg::OP_MOVE ? m[1] : half_sz[1] + 2);
                req.z = near(origin[2], req.op == tvga_pkg::OP_MOVE ? m[2] : half_sz[2] + 2);
            end
            send_beat(req, 1'b0, '0);
        end
    endtask

    // stimulus
    initial begin
        t_voxel_res t;
        in_if.valid = 1'b0;
        in_if.data = '0;
        for (int a = 0; a < 3; a++) begin
            half_sz[a] = 16;
            origin[a] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: typed results after reset and at extremes, rest predicted
        t = '0; t.addr = 27'd17968; t.in_window = 1'b1;
        add_row(tvga_pkg::OP_LOOKUP, 20'd0, 20'd0, 20'd0, 1'b1, t);
        add_row(tvga_pkg::OP_LOOKUP, 20'h80000, 20'h7FFFF, 20'h7FFFF, 1'b0, '0);
        add_row(tvga_pkg::OP_LOOKUP, 20'hFFFF0, 20'd16, 20'hFFFEF, 1'b0, '0);
        t = '0;
        add_row(tvga_pkg::OP_MOVE, 20'd0, 20'd0, 20'd0, 1'b1, t);
        t = '0; t.start_x = 9'h1F0; t.cnt_x = 9'd33;
        add_row(tvga_pkg::OP_MOVE, 20'd0, 20'd0, 20'd33, 1'b1, t);
        t = '0; t.reset_all = 1'b1;
        add_row(tvga_pkg::OP_MOVE, 20'd0, 20'd0, 20'd67, 1'b1, t);
        add_row(tvga_pkg::OP_MOVE, 20'd0, 20'h7FFFF, 20'h80000, 1'b1, t);
        add_row(tvga_pkg::OP_LOOKUP, 20'd0, 20'h7FFFF, 20'h80000, 1'b0, '0);
        add_row(tvga_pkg::OP_MOVE, 20'd5, 20'h7FFF0, 20'h80000, 1'b0, '0);
        add_row(tvga_pkg::OP_MOVE, 20'd2, 20'h7FFF0, 20'h80021, 1'b0, '0);
        add_row(tvga_pkg::OP_MOVE, 20'd2, 20'h7FFF0, 20'h80000, 1'b0, '0);
        add_row(tvga_pkg::OP_MOVE, 20'hFFFE1, 20'h7FFFF, 20'h80000, 1'b0, '0);
        add_row(tvga_pkg::OP_LOOKUP, 20'hFFFF2, 20'h7FFFF, 20'h80011, 1'b0, '0);
        add_row(tvga_pkg::OP_LOOKUP, 20'hFFFF1, 20'h7FFEE, 20'h7FFFF, 1'b0, '0);
        foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        // default half sizes
        random_beats(330);
        wait_idle();
        write_half(tvga_pkg::REG_HALF_X, 8'd0);
        write_half(tvga_pkg::REG_HALF_Y, 8'd0);
        write_half(tvga_pkg::REG_HALF_Z, 8'd0);
        random_beats(300);
        wait_idle();
        write_half(tvga_pkg::REG_HALF_X, 8'd255);
        write_half(tvga_pkg::REG_HALF_Y, 8'd255);
        write_half(tvga_pkg::REG_HALF_Z, 8'd255);
        random_beats(330);
        wait_idle();
        write_half(tvga_pkg::REG_HALF_X, 8'd255);
        write_half(tvga_pkg::REG_HALF_Y, 8'd0);
        write_half(tvga_pkg::REG_HALF_Z, 8'd7);
        random_beats(330);
        wait_idle();
        write_half(tvga_pkg::REG_HALF_X, 8'($urandom_range(1, 254)));
        write_half(tvga_pkg::REG_HALF_Y, 8'($urandom_range(1, 254)));
        write_half(tvga_pkg::REG_HALF_Z, 8'($urandom_range(1, 254)));
        random_beats(330);

        wait_idle();
        $display("covered %0d beats in five half size settings, %0d moves, %0d full resets",
                 beats_in, n_moves, n_full);
        if (errors == 0) begin
            $display("toroidal_voxel_grid_addresser_core_test OK");
        end else begin
            $display("toroidal_voxel_grid_addresser_core_test NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #60ms;
        $display("timeout with %0d results outstanding", pending_res.size());
        $display("toroidal_voxel_grid_addresser_core_test NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
